// ===== src/bfa_pkg.sv =====
// bfa_pkg: shared types, command codes and microcode ROM for the GF(2^m) arithmetic unit.
// No dependencies; imported by bfa_gfmul, binary_field_arith_unit_top, bfa_result_checker and the testbench top.
package bfa_pkg;

	localparam int UPC_W     = 4;
	localparam int MUL_DIGIT = 4;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_MUL = 2'd1;
	localparam logic [1:0] CMD_POW = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP      = 4'd0,
		OP_LOAD     = 4'd1,
		OP_ADD      = 4'd2,
		OP_START_AB = 4'd3,
		OP_ACC_MUL  = 4'd4,
		OP_POW_INIT = 4'd5,
		OP_START_SQ = 4'd6,
		OP_START_MA = 4'd7,
		OP_ACC_DEC  = 4'd8,
		OP_OUT      = 4'd9
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER    = 4'd0,
		C_ALWAYS   = 4'd1,
		C_NOREQ    = 4'd2,
		C_CMD_MUL  = 4'd3,
		C_CMD_POW  = 4'd4,
		C_MBUSY    = 4'd5,
		C_EBIT_CLR = 4'd6,
		C_K_NZ     = 4'd7,
		C_OUT_FULL = 4'd8
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} uword_t;

	localparam logic [UPC_W-1:0] UPC_LOAD     = 4'd0;
	localparam logic [UPC_W-1:0] UPC_DISPATCH = 4'd1;
	localparam logic [UPC_W-1:0] UPC_MUL      = 4'd4;
	localparam logic [UPC_W-1:0] UPC_MWAIT    = 4'd5;
	localparam logic [UPC_W-1:0] UPC_POW      = 4'd7;
	localparam logic [UPC_W-1:0] UPC_SQ       = 4'd8;
	localparam logic [UPC_W-1:0] UPC_SQWAIT   = 4'd9;
	localparam logic [UPC_W-1:0] UPC_MAWAIT   = 4'd12;
	localparam logic [UPC_W-1:0] UPC_NEXTBIT  = 4'd13;
	localparam logic [UPC_W-1:0] UPC_OUT      = 4'd15;

	// fall-through is upc+1; last step wraps back to the load step
	function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
		uword_t w;
		w = '{OP_NOP, C_NEVER, UPC_LOAD};
		unique case (addr)
			4'd0:  w = '{OP_LOAD,     C_NOREQ,    UPC_LOAD};
			4'd1:  w = '{OP_NOP,      C_CMD_MUL,  UPC_MUL};
			4'd2:  w = '{OP_NOP,      C_CMD_POW,  UPC_POW};
			4'd3:  w = '{OP_ADD,      C_ALWAYS,   UPC_OUT};
			4'd4:  w = '{OP_START_AB, C_NEVER,    UPC_LOAD};
			4'd5:  w = '{OP_NOP,      C_MBUSY,    UPC_MWAIT};
			4'd6:  w = '{OP_ACC_MUL,  C_ALWAYS,   UPC_OUT};
			4'd7:  w = '{OP_POW_INIT, C_NEVER,    UPC_LOAD};
			4'd8:  w = '{OP_START_SQ, C_NEVER,    UPC_LOAD};
			4'd9:  w = '{OP_NOP,      C_MBUSY,    UPC_SQWAIT};
			4'd10: w = '{OP_ACC_MUL,  C_EBIT_CLR, UPC_NEXTBIT};
			4'd11: w = '{OP_START_MA, C_NEVER,    UPC_LOAD};
			4'd12: w = '{OP_NOP,      C_MBUSY,    UPC_MAWAIT};
			4'd13: w = '{OP_ACC_DEC,  C_K_NZ,     UPC_SQ};
			4'd14: w = '{OP_NOP,      C_NEVER,    UPC_LOAD};
			4'd15: w = '{OP_OUT,      C_OUT_FULL, UPC_OUT};
			default: w = '{OP_NOP, C_ALWAYS, UPC_LOAD};
		endcase
		return w;
	endfunction

endpackage

// ===== src/binary_field_arith_unit_top.sv =====
// GF(2^m) arithmetic unit (add / multiply / exponentiate), microcoded sequencer.
// Requests are handled one at a time: the next request is taken only after the current result
// has been written to the output register, and may be taken while that result waits there.
// The field multiplier (4 bits per cycle) paces multiply steps.
// Reset (arst_n, async low): sequencer to load step, output empty, polynomial x^m+x+1.
module binary_field_arith_unit_top #(
	parameter int FIELD_BITS = 15
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// operand_a, operand_b, zero pad
	input  logic [((2*FIELD_BITS+7)/8)*8-1:0]         s_axis_tdata,
	// command
	input  logic [1:0]                                s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// result, zero pad
	output logic [((FIELD_BITS+7)/8)*8-1:0]           m_axis_tdata,
	input  logic                                      cfg_wr_en,
	input  logic [FIELD_BITS:0]                       cfg_wr_data
);
	import bfa_pkg::*;

	localparam int OUT_W = ((FIELD_BITS + 7) / 8) * 8;
	localparam int KW    = $clog2(FIELD_BITS);
	localparam logic [FIELD_BITS:0] POLY_RESET =
		(FIELD_BITS+1)'(3) | ((FIELD_BITS+1)'(1) << FIELD_BITS);

	logic [UPC_W-1:0]      upc_q;
	uword_t                uw;
	logic                  take;
	logic [FIELD_BITS-1:0] poly_q;
	logic [1:0]            cmd_q;
	logic [FIELD_BITS-1:0] a_q, e_q, acc_q;
	logic [KW-1:0]         k_q;
	logic                  out_valid_q;
	logic [FIELD_BITS-1:0] out_data_q;
	logic                  out_full;
	logic                  mul_start, mul_busy;
	logic [FIELD_BITS-1:0] mul_x, mul_y, mul_prod;

	assign uw       = ucode_rom(upc_q);
	assign out_full = out_valid_q && !m_axis_tready;

	always_comb begin
		case (uw.cond)
			C_ALWAYS:   take = 1'b1;
			C_NOREQ:    take = !s_axis_tvalid;
			C_CMD_MUL:  take = (cmd_q == CMD_MUL);
			C_CMD_POW:  take = (cmd_q == CMD_POW);
			C_MBUSY:    take = mul_busy;
			C_EBIT_CLR: take = !e_q[k_q];
			C_K_NZ:     take = (k_q != '0);
			C_OUT_FULL: take = out_full;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_LOAD;
		end else begin
			upc_q <= take ? uw.target : upc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET[FIELD_BITS-1:0];
		end else if (cfg_wr_en) begin
			poly_q <= cfg_wr_data[FIELD_BITS-1:0];
		end
	end

	assign s_axis_tready = (uw.op == OP_LOAD);

	always_comb begin
		mul_start = 1'b0;
		mul_x     = acc_q;
		mul_y     = acc_q;
		unique case (uw.op)
			OP_START_AB: begin
				mul_start = 1'b1;
				mul_x     = a_q;
				mul_y     = e_q;
			end
			OP_START_SQ: begin
				mul_start = 1'b1;
			end
			OP_START_MA: begin
				mul_start = 1'b1;
				mul_y     = a_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_ADD;
			k_q   <= '0;
		end else begin
			if (uw.op == OP_LOAD && s_axis_tvalid) begin
				cmd_q <= s_axis_tuser;
			end
			if (uw.op == OP_POW_INIT) begin
				k_q <= KW'(FIELD_BITS - 1);
			end else if (uw.op == OP_ACC_DEC) begin
				k_q <= k_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (s_axis_tvalid) begin
					a_q <= s_axis_tdata[FIELD_BITS-1:0];
					e_q <= s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
				end
			end
			OP_ADD:      acc_q <= (cmd_q == CMD_ADD) ? (a_q ^ e_q) : '0;
			OP_POW_INIT: acc_q <= FIELD_BITS'(1);
			OP_ACC_MUL, OP_ACC_DEC: acc_q <= mul_prod;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_OUT && !out_full) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_OUT && !out_full) begin
			out_data_q <= acc_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

	bfa_gfmul #(
		.FIELD_BITS(FIELD_BITS)
	) u_gfmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.x     (mul_x),
		.y     (mul_y),
		.poly  (poly_q),
		.busy  (mul_busy),
		.prod  (mul_prod)
	);

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (upc_q == UPC_DISPATCH))
		else $error("accepted request did not go to dispatch");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier started while busy");

	a_out_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_OUT && !out_full) |=> (m_axis_tvalid && upc_q == UPC_LOAD))
		else $error("result not emitted from output step");

endmodule

// ===== src/bfa_gfmul.sv =====
// bfa_gfmul: digit-serial GF(2^m) multiplier, MSB first, MUL_DIGIT bits per cycle.
// Depends on bfa_pkg.
module bfa_gfmul #(
	parameter int FIELD_BITS = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [FIELD_BITS-1:0] x,
	input  logic [FIELD_BITS-1:0] y,
	input  logic [FIELD_BITS-1:0] poly,
	output logic                  busy,
	output logic [FIELD_BITS-1:0] prod
);
	import bfa_pkg::*;

	localparam int NCYC = (FIELD_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int YW   = NCYC * MUL_DIGIT;
	localparam int CW   = $clog2(NCYC + 1);

	logic [FIELD_BITS-1:0] p_q, x_q, p_n;
	logic [YW-1:0]         y_q, y_n;
	logic [CW-1:0]         cnt_q;

	always_comb begin
		logic [FIELD_BITS-1:0] p;
		logic [YW-1:0]         yy;
		logic                  msb;
		p  = p_q;
		yy = y_q;
		for (int j = 0; j < MUL_DIGIT; j++) begin
			msb = p[FIELD_BITS-1];
			p   = (p << 1) ^ (msb ? poly : '0);
			if (yy[YW-1]) begin
				p = p ^ x_q;
			end
			yy = yy << 1;
		end
		p_n = p;
		y_n = yy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NCYC);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= '0;
			x_q <= x;
			y_q <= YW'(y);
		end else if (busy) begin
			p_q <= p_n;
			y_q <= y_n;
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = p_q;

endmodule

// ===== test/bfa_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for binary_field_arith_unit_top: watches the request, result and config ports,
// predicts each GF(2^m) result and compares it in order. Depends on bfa_pkg for command codes.
module bfa_result_checker #(
	parameter int FIELD_BITS = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [((2*FIELD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic [1:0]                        s_axis_tuser,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [((FIELD_BITS+7)/8)*8-1:0]   m_axis_tdata,
	input  logic                              cfg_wr_en,
	input  logic [FIELD_BITS:0]               cfg_wr_data,
	output int                                fail_count,
	output int                                pending
);
	import bfa_pkg::*;

	localparam int PW = 2*FIELD_BITS - 1;
	localparam logic [FIELD_BITS:0] RESET_POLY = (FIELD_BITS+1)'((1 << FIELD_BITS) | 3);

	typedef struct {
		logic [1:0]            cmd;
		logic [FIELD_BITS-1:0] a;
		logic [FIELD_BITS-1:0] b;
		logic [FIELD_BITS-1:0] res;
	} request_result_t;

	request_result_t expected_results[$];
	logic [FIELD_BITS:0] poly;
	int errors = 0;
	int pending_q = 0;

	assign fail_count = errors;
	assign pending = pending_q;

	// carry-less product, then reduction; leading term always present
	function automatic logic [FIELD_BITS-1:0] field_mul(input logic [FIELD_BITS-1:0] x,
			input logic [FIELD_BITS-1:0] y, input logic [FIELD_BITS:0] p);
		logic [PW-1:0] xe;
		logic [PW-1:0] pe;
		logic [PW-1:0] prod;
		xe = PW'(x);
		pe = PW'(p);
		pe[FIELD_BITS] = 1'b1;
		prod = '0;
		for (int i = 0; i < FIELD_BITS; i++)
			if (y[i])
				prod ^= xe << i;
		for (int i = 2*FIELD_BITS - 2; i >= FIELD_BITS; i--)
			if (prod[i])
				prod ^= pe << (i - FIELD_BITS);
		return prod[FIELD_BITS-1:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] field_pow(input logic [FIELD_BITS-1:0] x,
			input logic [FIELD_BITS-1:0] e, input logic [FIELD_BITS:0] p);
		logic [FIELD_BITS-1:0] acc;
		acc = FIELD_BITS'(1);
		for (int i = FIELD_BITS - 1; i >= 0; i--) begin
			acc = field_mul(acc, acc, p);
			if (e[i])
				acc = field_mul(acc, x, p);
		end
		return acc;
	endfunction

	function automatic logic [FIELD_BITS-1:0] predict_result(input logic [1:0] cmd,
			input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b,
			input logic [FIELD_BITS:0] p);
		case (cmd)
			CMD_ADD: return a ^ b;
			CMD_MUL: return field_mul(a, b, p);
			CMD_POW: return field_pow(a, b, p);
			default: return '0;
		endcase
	endfunction

	always @(posedge clk) begin : watch
		request_result_t req;
		request_result_t exp_r;
		logic [FIELD_BITS-1:0] got;
		if (!arst_n) begin
			poly = RESET_POLY;
			expected_results.delete();
		end else begin
			if (cfg_wr_en)
				poly = cfg_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[FIELD_BITS-1:0];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result %h with no request outstanding", $realtime, got);
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r.res) begin
						errors++;
						$display("%0t: cmd %0d a=%h b=%h poly=%h: expected %h, got %h",
							$realtime, exp_r.cmd, exp_r.a, exp_r.b, poly, exp_r.res, got);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.cmd = s_axis_tuser;
				req.a = s_axis_tdata[FIELD_BITS-1:0];
				req.b = s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
				req.res = predict_result(req.cmd, req.a, req.b, poly);
				expected_results.push_back(req);
			end
		end
		pending_q <= expected_results.size();
	end

endmodule

// ===== test/tb_binary_field_arith_unit_top.sv =====
`timescale 1ns / 100ps
// Testbench top for binary_field_arith_unit_top: reset, directed and random requests across
// several reduction polynomials, random stalls on both sides. Checking is in bfa_result_checker.
module tb_binary_field_arith_unit_top;
	import bfa_pkg::*;

	localparam int FIELD_BITS = 15;
	localparam int IN_W = ((2*FIELD_BITS+7)/8)*8;
	localparam int OUT_W = ((FIELD_BITS+7)/8)*8;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [FIELD_BITS-1:0] ALL_ONES = '1;
	localparam int LONG_HOLD = 400;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int DRAIN_CYCLES = 250;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_wr_en;
	logic [FIELD_BITS:0] cfg_wr_data;
	int fail_count;
	int pending;
	bit calm;
	bit hold_req;

	binary_field_arith_unit_top #(.FIELD_BITS(FIELD_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	bfa_result_checker #(.FIELD_BITS(FIELD_BITS)) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#20_000_000;
		$display("tb_binary_field_arith_unit_top NOT OK");
		$finish;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return FIELD_BITS'($urandom_range(0, (1 << FIELD_BITS) - 1));
		if (r < 78)
			return '0;
		if (r < 86)
			return ALL_ONES;
		if (r < 94)
			return FIELD_BITS'(1 << $urandom_range(0, FIELD_BITS - 1));
		return FIELD_BITS'(1);
	endfunction

	function automatic logic [FIELD_BITS:0] phase_poly(input int p);
		case (p)
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h0003;  // leading term bit clear
			4: return 16'h0000;
			5: return (FIELD_BITS+1)'($urandom_range(0, 16'hFFFF));
			6: return 16'h7FFF;
			default: return (FIELD_BITS+1)'(16'h8000 | $urandom_range(0, 16'h7FFF));
		endcase
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [FIELD_BITS-1:0] a,
			input logic [FIELD_BITS-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= IN_W'({b, a});
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random();
		logic [1:0] cmd;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			cmd = CMD_ADD;
		else if (r < 65)
			cmd = CMD_MUL;
		else if (r < 95)
			cmd = CMD_POW;
		else
			cmd = CMD_UNUSED;
		send_request(cmd, pick_operand(), pick_operand());
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_poly(input logic [FIELD_BITS:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_ADD;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_ADD, '0, '0);
		send_request(CMD_ADD, ALL_ONES, ALL_ONES);
		send_request(CMD_ADD, ALL_ONES, '0);
		send_request(CMD_ADD, 15'h5555, 15'h2AAA);
		send_request(CMD_MUL, ALL_ONES, ALL_ONES);
		send_request(CMD_MUL, '0, ALL_ONES);
		send_request(CMD_MUL, 15'h0001, 15'h1234);
		send_request(CMD_MUL, 15'h4000, 15'h4000);
		send_request(CMD_MUL, ALL_ONES, 15'h0001);
		// zero exponent, zero base included
		send_request(CMD_POW, '0, '0);
		send_request(CMD_POW, 15'h1234, '0);
		send_request(CMD_POW, ALL_ONES, ALL_ONES);
		send_request(CMD_POW, '0, 15'h0005);
		send_request(CMD_POW, 15'h0002, ALL_ONES);
		send_request(CMD_POW, 15'h4000, 15'h0001);
		send_request(CMD_UNUSED, ALL_ONES, ALL_ONES);
		send_request(CMD_UNUSED, '0, '0);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				write_poly(phase_poly(p));
			calm = (p == 2 || p == 6);
			if (p == 3)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == PHASE_ITEMS / 2)
					wait_drained();
				send_random();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_binary_field_arith_unit_top OK");
		else
			$display("tb_binary_field_arith_unit_top NOT OK");
		$finish;
	end

endmodule
